FILE: rtl/icu_pkg.sv
// Shared types and codes for the integer calculator unit.
package icu_pkg;

    localparam int OP_W     = 3;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_MUL     = 3'd2,
        OP_DIV     = 3'd3,
        OP_REM     = 3'd4,
        OP_POW     = 3'd5,
        OP_FACT    = 3'd6,
        OP_INVALID = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_DIV0    = 2'd1,
        ST_NEGFACT = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MUL_WAIT,
        S_DIV_RUN,
        S_POW_STEP,
        S_POW_ACC,
        S_POW_SQR,
        S_FACT_STEP,
        S_FACT_ACC,
        S_FINISH
    } state_t;

endpackage

FILE: rtl/icu_mul.sv
// Shared multiplier with registered low-half product.
module icu_mul #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic [DATA_WIDTH-1:0] p
);

    logic [DATA_WIDTH-1:0] prod;
    logic [DATA_WIDTH-1:0] p_reg;

    assign prod = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= prod;
    end

    assign p = p_reg;

endmodule

FILE: rtl/icu_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module icu_div #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] r_reg, r_next;
    logic [DATA_WIDTH-1:0] q_reg, q_next;
    logic [DATA_WIDTH-1:0] d_reg, d_next;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;

    assign shifted = {r_reg, q_reg[DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        r_next      = r_reg;
        q_next      = q_reg;
        d_next      = d_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = CW'(DATA_WIDTH);
            r_next      = '0;
            q_next      = dividend;
            d_next      = divisor;
        end
        else if (active_reg)
        begin
            if (!diff[DATA_WIDTH])
            begin
                r_next = diff[DATA_WIDTH-1:0];
                q_next = {q_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[DATA_WIDTH-1:0];
                q_next = {q_reg[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

FILE: rtl/integer_calculator_unit.sv
// Top level of the integer calculator unit: sequencer around a shared multiplier and divider.
//
// Input channel s_axis: one transaction carries an op code and two signed operands.
// Output channel m_axis: one transaction per input carries the result and a status.
// Status: ok, divide by zero, negative factorial, invalid op; result is zero on error.
// One operation runs at a time; s_axis_tready is high only while the sequencer is idle.
// Per op: add, sub, the error cases, power with exponent <= 0 and factorial of
//   2*DATA_WIDTH or more are settled in S_EXEC; mul waits for the registered product;
//   div and rem run the divider; power takes each exponent bit up to its highest set
//   bit, multiplying the accumulator by the base on a set bit and squaring the base;
//   factorial of n multiplies the accumulator by n down to 2.
// The next transaction is taken only after the sequencer has finished the last one.
// Power and factorial are bound by the single registered multiplier,
// div and rem by the one-bit-per-cycle restoring divider.
// The result sits in an output register; a new input is taken while it waits.
// If the receiver stalls, the next finished result waits in the sequencer until
// the output register frees.
// Reset (rst_n, async, active low) returns the sequencer to idle and drops m_axis_tvalid.
module integer_calculator_unit
    import icu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // op[2:0], operand_a[34:3], operand_b[66:35], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // result[31:0], status[33:32], zero
);

    localparam int KW         = $clog2(2 * DATA_WIDTH);
    localparam int FACT_LIMIT = 2 * DATA_WIDTH;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH-1:0] y_reg, y_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    status_t               st_reg, st_next;
    logic [FIELD_W-1:0]    out_res_reg, out_res_next;
    status_t               out_st_reg, out_st_next;
    logic                  out_valid_reg, out_valid_next;

    logic signed [FIELD_W-1:0] in_a;
    logic signed [FIELD_W-1:0] in_b;
    logic [DATA_WIDTH-1:0]     mag_x;
    logic [DATA_WIDTH-1:0]     mag_y;
    logic [DATA_WIDTH-1:0]     mul_a;
    logic [DATA_WIDTH-1:0]     mul_b;
    logic [DATA_WIDTH-1:0]     mul_p;
    logic                      div_start;
    logic                      div_done;
    logic [DATA_WIDTH-1:0]     div_quo;
    logic [DATA_WIDTH-1:0]     div_rem;

    assign in_a  = s_axis_tdata[34:3];
    assign in_b  = s_axis_tdata[66:35];
    assign mag_x = x_reg[DATA_WIDTH-1] ? ('0 - x_reg) : x_reg;
    assign mag_y = y_reg[DATA_WIDTH-1] ? ('0 - y_reg) : y_reg;

    icu_mul #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    icu_div #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_x),
        .divisor   (mag_y),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        k_next         = k_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        out_res_next   = out_res_reg;
        out_st_next    = out_st_reg;
        out_valid_next = out_valid_reg;
        mul_a          = x_reg;
        mul_b          = y_reg;
        div_start      = 1'b0;
        s_axis_tready  = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    op_next    = op_t'(s_axis_tdata[OP_W-1:0]);
                    x_next     = DATA_WIDTH'(in_a);
                    y_next     = DATA_WIDTH'(in_b);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                st_next    = ST_OK;
                state_next = S_FINISH;
                case (op_reg)
                    OP_ADD:
                    begin
                        res_next = x_reg + y_reg;
                    end
                    OP_SUB:
                    begin
                        res_next = x_reg - y_reg;
                    end
                    OP_MUL:
                    begin
                        state_next = S_MUL_WAIT;
                    end
                    OP_DIV, OP_REM:
                    begin
                        if (y_reg == '0)
                        begin
                            res_next = '0;
                            st_next  = ST_DIV0;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV_RUN;
                        end
                    end
                    OP_POW:
                    begin
                        if ((y_reg == '0) || y_reg[DATA_WIDTH-1])
                        begin
                            res_next = DATA_WIDTH'(1);
                        end
                        else
                        begin
                            acc_next   = DATA_WIDTH'(1);
                            state_next = S_POW_STEP;
                        end
                    end
                    OP_FACT:
                    begin
                        if (x_reg[DATA_WIDTH-1])
                        begin
                            res_next = '0;
                            st_next  = ST_NEGFACT;
                        end
                        else if (x_reg >= DATA_WIDTH'(FACT_LIMIT))
                        begin
                            res_next = '0;
                        end
                        else
                        begin
                            acc_next   = DATA_WIDTH'(1);
                            k_next     = x_reg[KW-1:0];
                            state_next = S_FACT_STEP;
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                        st_next  = ST_INVALID;
                    end
                endcase
            end
            S_MUL_WAIT:
            begin
                res_next   = mul_p;
                state_next = S_FINISH;
            end
            S_DIV_RUN:
            begin
                if (div_done)
                begin
                    if (op_reg == OP_DIV)
                    begin
                        res_next = (x_reg[DATA_WIDTH-1] ^ y_reg[DATA_WIDTH-1]) ?
                                   ('0 - div_quo) : div_quo;
                    end
                    else
                    begin
                        res_next = x_reg[DATA_WIDTH-1] ? ('0 - div_rem) : div_rem;
                    end
                    state_next = S_FINISH;
                end
            end
            S_POW_STEP:
            begin
                if (y_reg == '0)
                begin
                    res_next   = acc_reg;
                    state_next = S_FINISH;
                end
                else if (y_reg[0])
                begin
                    mul_a      = acc_reg;
                    mul_b      = x_reg;
                    state_next = S_POW_ACC;
                end
                else
                begin
                    mul_a      = x_reg;
                    mul_b      = x_reg;
                    state_next = S_POW_SQR;
                end
            end
            S_POW_ACC:
            begin
                acc_next   = mul_p;
                mul_a      = x_reg;
                mul_b      = x_reg;
                state_next = S_POW_SQR;
            end
            S_POW_SQR:
            begin
                x_next     = mul_p;
                y_next     = y_reg >> 1;
                state_next = S_POW_STEP;
            end
            S_FACT_STEP:
            begin
                if (k_reg <= KW'(1))
                begin
                    res_next   = acc_reg;
                    state_next = S_FINISH;
                end
                else
                begin
                    mul_a      = acc_reg;
                    mul_b      = DATA_WIDTH'(k_reg);
                    state_next = S_FACT_ACC;
                end
            end
            S_FACT_ACC:
            begin
                acc_next   = mul_p;
                k_next     = k_reg - 1'b1;
                state_next = S_FACT_STEP;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_res_next   = FIELD_W'(res_reg);
                    out_st_next    = st_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        acc_reg     <= acc_next;
        k_reg       <= k_next;
        res_reg     <= res_next;
        st_reg      <= st_next;
        out_res_reg <= out_res_next;
        out_st_reg  <= out_st_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_st_reg, out_res_reg};

endmodule

FILE: bench/tb_integer_calculator_unit.sv
// Testbench for integer_calculator_unit: directed table plus random ops, checked by a predictor.
`timescale 1ns / 1ps

module tb_integer_calculator_unit;
    import icu_pkg::*;

    localparam int NUM_RANDOM     = 850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [FIELD_W-1:0] res;
        status_t            st;
    } calc_result_t;

    typedef struct packed {
        op_t                op;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic               known;
        logic [FIELD_W-1:0] res;
        status_t            st;
    } calc_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // op[2:0], operand_a[34:3], operand_b[66:35], zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // result[31:0], status[33:32], zero

    calc_result_t pending_outcomes[$];
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           stall_left = 0;
    bit           idling_on = 1'b1;

    // directed rows; known = 1 means the expected value is given in the row
    calc_row_t calc_table [0:24] = '{
        '{OP_ADD, 32'h7fffffff, 32'h00000001, 1'b1, 32'h80000000, ST_OK},
        '{OP_SUB, 32'h80000000, 32'h00000001, 1'b1, 32'h7fffffff, ST_OK},
        '{OP_MUL, 32'h80000000, 32'hffffffff, 1'b1, 32'h80000000, ST_OK},
        '{OP_MUL, 32'h7fffffff, 32'h7fffffff, 1'b1, 32'h00000001, ST_OK},
        '{OP_DIV, 32'h00000007, 32'h00000000, 1'b1, 32'h00000000, ST_DIV0},
        '{OP_REM, 32'hfffffffb, 32'h00000000, 1'b1, 32'h00000000, ST_DIV0},
        '{OP_DIV, 32'h80000000, 32'hffffffff, 1'b1, 32'h80000000, ST_OK},
        '{OP_REM, 32'h80000000, 32'hffffffff, 1'b1, 32'h00000000, ST_OK},
        '{OP_DIV, 32'hfffffff9, 32'h00000002, 1'b1, 32'hfffffffd, ST_OK},
        '{OP_REM, 32'hfffffff9, 32'h00000002, 1'b1, 32'hffffffff, ST_OK},
        '{OP_DIV, 32'h00000007, 32'hfffffffe, 1'b0, 32'h00000000, ST_OK},
        '{OP_REM, 32'h00000007, 32'hfffffffe, 1'b0, 32'h00000000, ST_OK},
        '{OP_POW, 32'h00000000, 32'h00000000, 1'b1, 32'h00000001, ST_OK},
        '{OP_POW, 32'h00000005, 32'hfffffffd, 1'b1, 32'h00000001, ST_OK},
        '{OP_POW, 32'h00000002, 32'h00000020, 1'b1, 32'h00000000, ST_OK},
        '{OP_POW, 32'h00000003, 32'h7fffffff, 1'b0, 32'h00000000, ST_OK},
        '{OP_POW, 32'hfffffffe, 32'h0000001f, 1'b0, 32'h00000000, ST_OK},
        '{OP_FACT, 32'h00000000, 32'h12345678, 1'b1, 32'h00000001, ST_OK},
        '{OP_FACT, 32'h0000000c, 32'h00000000, 1'b1, 32'd479001600, ST_OK},
        '{OP_FACT, 32'h0000003f, 32'hffffffff, 1'b0, 32'h00000000, ST_OK},
        '{OP_FACT, 32'h00000040, 32'h00000000, 1'b1, 32'h00000000, ST_OK},
        '{OP_FACT, 32'h7fffffff, 32'h80000000, 1'b1, 32'h00000000, ST_OK},
        '{OP_FACT, 32'hffffffff, 32'h00000000, 1'b1, 32'h00000000, ST_NEGFACT},
        '{OP_FACT, 32'h80000000, 32'h7fffffff, 1'b1, 32'h00000000, ST_NEGFACT},
        '{OP_INVALID, 32'h7fffffff, 32'h80000000, 1'b1, 32'h00000000, ST_INVALID}
    };

    integer_calculator_unit #(.DATA_WIDTH(FIELD_W)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    function automatic calc_result_t calc_outcome(op_t op, logic [FIELD_W-1:0] a,
                                                  logic [FIELD_W-1:0] b);
        logic [FIELD_W-1:0] ma;
        logic [FIELD_W-1:0] mb;
        logic [FIELD_W-1:0] acc;
        logic [FIELD_W-1:0] base;
        calc_result_t       r;
        r.res = '0;
        r.st  = ST_OK;
        case (op)
            OP_ADD: r.res = a + b;
            OP_SUB: r.res = a - b;
            OP_MUL: r.res = a * b;
            OP_DIV, OP_REM:
            begin
                if (b == '0)
                    r.st = ST_DIV0;
                else
                begin
                    ma = a[FIELD_W-1] ? -a : a;
                    mb = b[FIELD_W-1] ? -b : b;
                    if (op == OP_DIV)
                    begin
                        r.res = ma / mb;
                        if (a[FIELD_W-1] != b[FIELD_W-1])
                            r.res = -r.res;
                    end
                    else
                    begin
                        r.res = ma % mb;
                        if (a[FIELD_W-1])
                            r.res = -r.res;
                    end
                end
            end
            OP_POW:
            begin
                if (b == '0 || b[FIELD_W-1])
                    r.res = 1;
                else
                begin
                    acc  = 1;
                    base = a;
                    for (int i = 0; i < FIELD_W - 1; i++)
                    begin
                        if (b[i])
                            acc = acc * base;
                        base = base * base;
                    end
                    r.res = acc;
                end
            end
            OP_FACT:
            begin
                if (a[FIELD_W-1])
                    r.st = ST_NEGFACT;
                else if (a >= 2 * FIELD_W)
                    r.res = '0;
                else
                begin
                    acc = 1;
                    for (int i = 2; i <= int'(a); i++)
                        acc = acc * FIELD_W'(i);
                    r.res = acc;
                end
            end
            default: r.st = ST_INVALID;
        endcase
        if (r.st != ST_OK)
            r.res = '0;
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 1;
            2: return '1;
            3: return {1'b1, {(FIELD_W-1){1'b0}}};
            4: return {1'b0, {(FIELD_W-1){1'b1}}};
            5, 6: return FIELD_W'($urandom_range(0, 40)) - FIELD_W'(20);
            default: return $urandom;
        endcase
    endfunction

    // called at a rising edge; returns at the rising edge where the transaction is taken
    task automatic issue_calc(op_t op, logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                              calc_result_t want);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, b, a, op};
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        pending_outcomes.push_back(want);
        @(posedge clk);
    endtask

    // receiver backpressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left    <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // result check and watchdog; values sampled at the falling edge before the edge that takes them
    always @(negedge clk)
    begin
        calc_result_t want;
        calc_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.res = m_axis_tdata[FIELD_W-1:0];
            got.st  = status_t'(m_axis_tdata[FIELD_W+STATUS_W-1:FIELD_W]);
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected transaction result=%h status=%0d",
                         $time, got.res, got.st);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got.res !== want.res)
                begin
                    mismatches++;
                    $display("%0t: result expected %h actual %h", $time, want.res, got.res);
                end
                if (got.st !== want.st)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_outcomes.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        calc_row_t          row;
        calc_result_t       want;
        op_t                op;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (calc_table[i])
        begin
            row = calc_table[i];
            if (row.known)
            begin
                want.res = row.res;
                want.st  = row.st;
            end
            else
            begin
                want = calc_outcome(row.op, row.a, row.b);
            end
            issue_calc(row.op, row.a, row.b, want);
        end

        for (int k = 0; k < NUM_RANDOM; k++)
        begin
            if (k % 40 == 0)
                idling_on = (k < NUM_RANDOM - 90) && ($urandom_range(0, 3) != 0);
            op = op_t'($urandom_range(0, 7));
            a  = pick_operand();
            b  = pick_operand();
            if (op == OP_POW && $urandom_range(0, 3) != 0)
                b = $urandom_range(0, 40);
            if (op == OP_FACT && $urandom_range(0, 3) != 0)
                a = $urandom_range(0, 70);
            issue_calc(op, a, b, calc_outcome(op, a, b));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: integer_calculator_unit.f
rtl/icu_pkg.sv
rtl/icu_mul.sv
rtl/icu_div.sv
rtl/integer_calculator_unit.sv
bench/tb_integer_calculator_unit.sv
